// ===== rtl/iirdf_pkg.sv =====
// Shared constants, types and the control program of the direct form I IIR filter.
package iirdf_pkg;

   // Sample and filter geometry.
   localparam int SAMPLE_WIDTH = 16;
   localparam int ORDER        = 2;
   localparam int HIST_DEPTH   = 2;

   // Register file geometry.
   localparam int COEF_W     = 16;
   localparam int A0_W       = 15;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_B0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A0      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_Y  = 3'd6;

   // Reset values of the coefficients (1.0 in Q2.14).
   localparam logic signed [COEF_W-1:0] COEF_ONE = 16'sd16384;
   localparam logic [A0_W-1:0]          A0_ONE   = 15'd16384;

   // Datapath widths. Five products of COEF_W x SAMPLE_WIDTH bits stay below
   // 2^(SAMPLE_WIDTH+17) in magnitude.
   localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
   localparam int ACC_W  = SAMPLE_WIDTH + 18;
   localparam int MAG_W  = SAMPLE_WIDTH + 17;
   localparam int CNT_W  = $clog2(MAG_W + 1);

   // Stream widths, padded to whole bytes.
   localparam int REQ_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SAMPLE_WIDTH + 1 + 7) / 8) * 8;

   // Sample range limits.
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [MAG_W-1:0] MAG_MAX =
      MAG_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);

   localparam int CLAMP_W = 34;
   localparam logic signed [CLAMP_W-1:0] CLAMP_HI =
      CLAMP_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [CLAMP_W-1:0] CLAMP_LO = -CLAMP_HI - 34'sd1;

   // Program counter.
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] PC_DIV    = 4'd8;
   localparam logic [PC_W-1:0] PC_FINISH = 4'd9;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_B0_X,
      MUL_B1_X1,
      MUL_B2_X2,
      MUL_A1_Y1,
      MUL_A2_Y2
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_INIT,
      DIV_STEP
   } div_op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_WAIT_INPUT,
      COND_DIV_LOOP,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      logic        take_input;
      logic        finish;
      logic        ret;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      div_op_type  div_op;
      cond_type    cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   typedef struct packed {
      logic last;
   } div_status_type;

   // One control word per step of the program.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{take_input: 1'b0, finish: 1'b0, ret: 1'b0, mul_sel: MUL_NONE,
            acc_op: ACC_HOLD, div_op: DIV_NONE, cond: COND_NEXT, target: PC_IDLE};
      case (pc)
         4'd0: begin
            w.take_input = 1'b1;
            w.cond       = COND_WAIT_INPUT;
            w.target     = PC_IDLE;
         end
         4'd1: w.mul_sel = MUL_B0_X;
         4'd2: begin
            w.mul_sel = MUL_B1_X1;
            w.acc_op  = ACC_LOAD;
         end
         4'd3: begin
            w.mul_sel = MUL_B2_X2;
            w.acc_op  = ACC_ADD;
         end
         4'd4: begin
            w.mul_sel = MUL_A1_Y1;
            w.acc_op  = ACC_ADD;
         end
         4'd5: begin
            w.mul_sel = MUL_A2_Y2;
            w.acc_op  = ACC_SUB;
         end
         4'd6: w.acc_op = ACC_SUB;
         4'd7: w.div_op = DIV_INIT;
         4'd8: begin
            w.div_op = DIV_STEP;
            w.cond   = COND_DIV_LOOP;
            w.target = PC_DIV;
         end
         4'd9: begin
            w.finish = 1'b1;
            w.ret    = 1'b1;
            w.cond   = COND_WAIT_OUT;
            w.target = PC_FINISH;
         end
         default: w.ret = 1'b1;
      endcase
      return w;
   endfunction

   // Brings the initial output value into the sample range.
   function automatic logic [SAMPLE_WIDTH-1:0] clamp_init(
      input logic signed [CSR_DATA_W-1:0] v);
      logic signed [CLAMP_W-1:0] w;
      logic signed [CLAMP_W-1:0] c;
      w = CLAMP_W'(v);
      if (w > CLAMP_HI) begin
         c = CLAMP_HI;
      end else if (w < CLAMP_LO) begin
         c = CLAMP_LO;
      end else begin
         c = w;
      end
      return c[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

// ===== rtl/iirdf_divider.sv =====
// Restoring serial divider: one quotient bit per step, unsigned magnitudes.
module iirdf_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iirdf_pkg::div_ctrl_type               ctrl,
   input  logic [iirdf_pkg::MAG_W-1:0]           dividend,
   input  logic [iirdf_pkg::A0_W-1:0]            divisor,
   output logic [iirdf_pkg::MAG_W-1:0]           quotient,
   output iirdf_pkg::div_status_type             status
);

   logic [iirdf_pkg::MAG_W-1:0] work_ff, work_in;
   logic [iirdf_pkg::A0_W-1:0]  rem_ff, rem_in;
   logic [iirdf_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic [iirdf_pkg::A0_W:0] trial;
   logic [iirdf_pkg::A0_W:0] diff;
   logic                     fits;

   always_comb begin
      trial = {rem_ff, work_ff[iirdf_pkg::MAG_W-1]};
      fits  = trial >= {1'b0, divisor};
      diff  = trial - {1'b0, divisor};
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (ctrl.init) begin
         work_in = dividend;
         rem_in  = '0;
         cnt_in  = iirdf_pkg::CNT_W'(iirdf_pkg::MAG_W);
      end else if (ctrl.step) begin
         // The dividend shifts out at the top while quotient bits enter at the bottom.
         work_in = {work_ff[iirdf_pkg::MAG_W-2:0], fits};
         rem_in  = fits ? diff[iirdf_pkg::A0_W-1:0] : trial[iirdf_pkg::A0_W-1:0];
         cnt_in  = cnt_ff - iirdf_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient    = work_ff;
   assign status.last = (cnt_ff == iirdf_pkg::CNT_W'(1));

endmodule

// ===== rtl/iir_direct_form_filter_unit.sv =====
// Top level of the second-order direct form I IIR filter with a microcoded sequencer.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------------
//  req     | in        | req_tvalid/tready   | req_tdata: sample_in
//  rsp     | out       | rsp_tvalid/tready   | rsp_tdata: sample_out, saturated, zero pad
//  csr     | in        | csr_wr_en           | csr_index, csr_wdata (write only)
//
// Each transaction runs from one input to the next through the input step, six steps of
// the single shared multiplier and accumulator, one divider load, MAG_W steps of the
// one-bit-per-cycle restoring divider, and one finishing step. The serial divide by
// coef_a0 takes the largest share of those steps.
// Reset is synchronous and active high; it restores every coefficient, clears the input
// history and loads the clamped initial output into the output history.
// A finished result waits in the output register while the next sample is accepted; the
// sequencer stalls only in its finishing step if that register is still full.
module iir_direct_form_filter_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   // Fields from bit 0 up: sample_in.
   input  logic [iirdf_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // Fields from bit 0 up: sample_out, saturated, zero padding.
   output logic [iirdf_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_wr_en,
   input  logic [iirdf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [iirdf_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SW = iirdf_pkg::SAMPLE_WIDTH;

   // Configuration registers.
   logic signed [iirdf_pkg::COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [iirdf_pkg::A0_W-1:0]          a0_ff;

   // Sequencer.
   logic [iirdf_pkg::PC_W-1:0] pc_ff, pc_in;
   iirdf_pkg::ucode_type       uc;
   logic                       jump;

   // Sample and histories.
   logic signed [SW-1:0] x_ff;
   logic signed [SW-1:0] xh_ff [iirdf_pkg::HIST_DEPTH];
   logic signed [SW-1:0] yh_ff [iirdf_pkg::HIST_DEPTH];

   // Multiply and accumulate.
   logic signed [iirdf_pkg::COEF_W-1:0] mul_coef;
   logic signed [SW-1:0]                mul_data;
   logic signed [iirdf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [iirdf_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [iirdf_pkg::MAG_W-1:0]         acc_mag;
   logic                                neg_ff, zero_ff;

   // Divider.
   iirdf_pkg::div_ctrl_type     div_ctrl;
   iirdf_pkg::div_status_type   div_status;
   logic [iirdf_pkg::MAG_W-1:0] quotient;

   // Result.
   logic            rsp_valid_ff;
   logic [SW-1:0]   rsp_sample_ff;
   logic            rsp_sat_ff;
   logic            out_free;
   logic            fire;
   logic            accept;
   logic [SW-1:0]   y_value;
   logic            y_sat;

   assign uc         = iirdf_pkg::ucode_rom(pc_ff);
   assign req_tready = uc.take_input;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = uc.finish && out_free;

   // Next step: a taken jump goes to the word's target, otherwise fall through or return.
   always_comb begin
      case (uc.cond)
         iirdf_pkg::COND_NEXT:       jump = 1'b0;
         iirdf_pkg::COND_WAIT_INPUT: jump = !req_tvalid;
         iirdf_pkg::COND_DIV_LOOP:   jump = !div_status.last;
         iirdf_pkg::COND_WAIT_OUT:   jump = !out_free;
         default:                    jump = 1'b0;
      endcase
      if (jump) begin
         pc_in = uc.target;
      end else if (uc.ret) begin
         pc_in = iirdf_pkg::PC_IDLE;
      end else begin
         pc_in = pc_ff + iirdf_pkg::PC_W'(1);
      end
   end

   // Operand selection. Taps above the filter order contribute nothing.
   always_comb begin
      mul_coef = '0;
      mul_data = '0;
      case (uc.mul_sel)
         iirdf_pkg::MUL_B0_X: begin
            mul_coef = b0_ff;
            mul_data = x_ff;
         end
         iirdf_pkg::MUL_B1_X1: begin
            mul_coef = (iirdf_pkg::ORDER >= 1) ? b1_ff : '0;
            mul_data = xh_ff[0];
         end
         iirdf_pkg::MUL_B2_X2: begin
            mul_coef = (iirdf_pkg::ORDER >= 2) ? b2_ff : '0;
            mul_data = xh_ff[1];
         end
         iirdf_pkg::MUL_A1_Y1: begin
            mul_coef = (iirdf_pkg::ORDER >= 1) ? a1_ff : '0;
            mul_data = yh_ff[0];
         end
         iirdf_pkg::MUL_A2_Y2: begin
            mul_coef = (iirdf_pkg::ORDER >= 2) ? a2_ff : '0;
            mul_data = yh_ff[1];
         end
         default: begin
            mul_coef = '0;
            mul_data = '0;
         end
      endcase
      prod_in = mul_coef * mul_data;
   end

   // The accumulator works on the product registered in the step before.
   always_comb begin
      case (uc.acc_op)
         iirdf_pkg::ACC_HOLD: acc_in = acc_ff;
         iirdf_pkg::ACC_LOAD: acc_in = iirdf_pkg::ACC_W'(prod_ff);
         iirdf_pkg::ACC_ADD:  acc_in = acc_ff + iirdf_pkg::ACC_W'(prod_ff);
         iirdf_pkg::ACC_SUB:  acc_in = acc_ff - iirdf_pkg::ACC_W'(prod_ff);
         default:             acc_in = acc_ff;
      endcase
      acc_mag = acc_ff[iirdf_pkg::ACC_W-1] ? iirdf_pkg::MAG_W'(-acc_ff)
                                           : iirdf_pkg::MAG_W'(acc_ff);
   end

   assign div_ctrl.init = (uc.div_op == iirdf_pkg::DIV_INIT);
   assign div_ctrl.step = (uc.div_op == iirdf_pkg::DIV_STEP);

   iirdf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (acc_mag),
      .divisor  (a0_ff),
      .quotient (quotient),
      .status   (div_status)
   );

   // The quotient magnitude truncates toward zero; the sign is put back and the value
   // saturated. A zero divisor sends any nonzero sum to the limit of its sign.
   always_comb begin
      if (a0_ff == '0) begin
         y_sat   = !zero_ff;
         y_value = zero_ff ? '0 : (neg_ff ? iirdf_pkg::SAMPLE_MIN : iirdf_pkg::SAMPLE_MAX);
      end else if (neg_ff) begin
         y_sat   = quotient > (iirdf_pkg::MAG_MAX + iirdf_pkg::MAG_W'(1));
         y_value = y_sat ? iirdf_pkg::SAMPLE_MIN : -quotient[SW-1:0];
      end else begin
         y_sat   = quotient > iirdf_pkg::MAG_MAX;
         y_value = y_sat ? iirdf_pkg::SAMPLE_MAX : quotient[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= iirdf_pkg::PC_IDLE;
         rsp_valid_ff <= 1'b0;
         b0_ff        <= iirdf_pkg::COEF_ONE;
         b1_ff        <= '0;
         b2_ff        <= '0;
         a0_ff        <= iirdf_pkg::A0_ONE;
         a1_ff        <= '0;
         a2_ff        <= '0;
         for (int i = 0; i < iirdf_pkg::HIST_DEPTH; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= iirdf_pkg::clamp_init('0);
         end
      end else begin
         pc_ff <= pc_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            xh_ff[0] <= x_ff;
            xh_ff[1] <= xh_ff[0];
            yh_ff[0] <= y_value;
            yh_ff[1] <= yh_ff[0];
         end else if (csr_wr_en && csr_index == iirdf_pkg::REG_INIT_Y) begin
            for (int i = 0; i < iirdf_pkg::HIST_DEPTH; i++) begin
               yh_ff[i] <= iirdf_pkg::clamp_init(csr_wdata);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               iirdf_pkg::REG_B0: b0_ff <= csr_wdata;
               iirdf_pkg::REG_B1: b1_ff <= csr_wdata;
               iirdf_pkg::REG_B2: b2_ff <= csr_wdata;
               iirdf_pkg::REG_A0: a0_ff <= csr_wdata[iirdf_pkg::A0_W-1:0];
               iirdf_pkg::REG_A1: a1_ff <= csr_wdata;
               iirdf_pkg::REG_A2: a2_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (accept) begin
         x_ff <= req_tdata[SW-1:0];
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (div_ctrl.init) begin
         neg_ff  <= acc_ff[iirdf_pkg::ACC_W-1];
         zero_ff <= (acc_ff == '0);
      end
      if (fire) begin
         rsp_sample_ff <= y_value;
         rsp_sat_ff    <= y_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = iirdf_pkg::RSP_DATA_W'({rsp_sat_ff, rsp_sample_ff});

   // One sample at a time: right after a transaction is accepted the input closes.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again while a sample is in progress");

   // A saturated result always sits at one of the range limits.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[SW] |->
         (rsp_tdata[SW-1:0] == iirdf_pkg::SAMPLE_MAX ||
          rsp_tdata[SW-1:0] == iirdf_pkg::SAMPLE_MIN))
      else $error("saturated flag set on a value inside the range");

   // A new result appears only out of the finishing step.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pc_ff) == iirdf_pkg::PC_FINISH)
      else $error("result raised outside the finishing step");

   // The divider only runs its loop with steps left.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      pc_ff == iirdf_pkg::PC_DIV && $past(pc_ff) == iirdf_pkg::PC_DIV |->
         $past(!div_status.last))
      else $error("divider loop continued past its last step");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the second-order direct form I IIR filter unit.
`timescale 1ns / 100ps

module testbench;
   import iirdf_pkg::*;

   // Index past the last register; writes to it must leave the filter untouched.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // Random samples after the directed table. The last TAIL_ITEMS of them run
   // with no random idling on either side.
   localparam int RANDOM_ITEMS = 700;
   localparam int TAIL_ITEMS   = 80;

   // The slowest correct run spends compute time, a sender gap and a receiver
   // stall on each sample, and the configuration drains add a little on top.
   // The limit is several times that.
   localparam int CYCLE_LIMIT = 600000;

   // Cycles allowed for a stray result to show up once everything has arrived.
   localparam int DRAIN_CYCLES = 60;

   localparam longint SAMPLE_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 64'sd1;

   // One filter output as it travels in rsp_tdata, minus the zero padding.
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    saturated;
   } filter_out_type;

   // Coefficient flavors for the random phases. Wide draws any 16-bit value.
   // Mild keeps the filter near unity gain, so most outputs stay in range.
   // Extreme draws only the range limits and zero.
   typedef enum logic [1:0] {
      MODE_WIDE,
      MODE_MILD,
      MODE_EXTREME
   } coef_mode_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_WRITE
   } row_kind_type;

   // One row of the directed table. A sample row either carries a typed-in
   // expectation or leaves the expectation to the filter model below.
   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]   value;
      bit                      typed;
      logic [SAMPLE_WIDTH-1:0] want_sample;
      bit                      want_sat;
   } stim_row_type;

   // Every input of the unit has a known value from time zero.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Shadow copy of the filter: register values and both histories, at their
   // reset values. The histories update the moment a transaction is accepted.
   logic signed [COEF_W-1:0]       b0_coef = COEF_ONE;
   logic signed [COEF_W-1:0]       b1_coef = '0;
   logic signed [COEF_W-1:0]       b2_coef = '0;
   logic [A0_W-1:0]                a0_coef = A0_ONE;
   logic signed [COEF_W-1:0]       a1_coef = '0;
   logic signed [COEF_W-1:0]       a2_coef = '0;
   logic signed [SAMPLE_WIDTH-1:0] x_past [0:1] = '{default: '0};
   logic signed [SAMPLE_WIDTH-1:0] y_past [0:1] = '{default: '0};

   // Outputs predicted for accepted samples, oldest first.
   filter_out_type pending_outputs [$];
   stim_row_type   directed_rows [$];

   int  error_count = 0;
   int  result_count = 0;
   int  cycle_count = 0;
   bit  quiet_tail = 1'b0;
   bit  sender_calm = 1'b0;
   int  stall_left = 0;

   iir_direct_form_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Filter model. The accumulator is the full feedforward sum minus the
   // feedback sum. Signed division truncates toward zero, which matches the
   // unit's divide by a0. A zero divisor sends any nonzero sum to the range
   // limit of its sign, while a zero sum gives zero without the saturation flag.
   function automatic filter_out_type filter_step(input logic signed [SAMPLE_WIDTH-1:0] x);
      longint         acc;
      longint         quo;
      filter_out_type r;
      acc = longint'(b0_coef) * longint'(x)
          + longint'(b1_coef) * longint'(x_past[0])
          + longint'(b2_coef) * longint'(x_past[1])
          - longint'(a1_coef) * longint'(y_past[0])
          - longint'(a2_coef) * longint'(y_past[1]);
      if (a0_coef == '0) begin
         quo = (acc > 0) ? SAMPLE_HI + 1 : (acc < 0) ? SAMPLE_LO - 1 : 0;
      end else begin
         quo = acc / longint'(a0_coef);
      end
      r.saturated = (quo > SAMPLE_HI) || (quo < SAMPLE_LO);
      if (quo > SAMPLE_HI) begin
         r.sample = SAMPLE_MAX;
      end else if (quo < SAMPLE_LO) begin
         r.sample = SAMPLE_MIN;
      end else begin
         r.sample = SAMPLE_WIDTH'(quo);
      end
      x_past[1] = x_past[0];
      x_past[0] = x;
      y_past[1] = y_past[0];
      y_past[0] = r.sample;
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef(input coef_mode_type mode, input int span);
      case (mode)
         MODE_MILD: begin
            return COEF_W'($urandom_range(0, 2 * span)) - COEF_W'(span);
         end
         MODE_EXTREME: begin
            case ($urandom_range(0, 2))
               0: return 16'h8000;
               1: return 16'h7FFF;
               default: return '0;
            endcase
         end
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR: cycle %0d, result %0d: %s", cycle_count, result_count, what);
      end
   endtask

   task automatic add_sample(input logic [SAMPLE_WIDTH-1:0] x, input bit typed,
                             input logic [SAMPLE_WIDTH-1:0] want_sample, input bit want_sat);
      stim_row_type row;
      row = '{ROW_SAMPLE, REG_UNUSED, x, typed, want_sample, want_sat};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '{ROW_WRITE, index, value, 1'b0, '0, 1'b0};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Hold the request channel idle until every predicted output has been taken.
   // The queue is polled on the falling edge so that the result check at the
   // rising edge has already run; the caller resumes on a rising edge.
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // A register write only happens with the unit idle. Writing the initial
   // output reloads both output history entries. At 16 bits the value is
   // already in range, so no clamp applies. The unused index changes nothing.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_outputs();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         REG_B0:     b0_coef = value;
         REG_B1:     b1_coef = value;
         REG_B2:     b2_coef = value;
         REG_A0:     a0_coef = value[A0_W-1:0];
         REG_A1:     a1_coef = value;
         REG_A2:     a2_coef = value;
         REG_INIT_Y: begin
            y_past[0] = value;
            y_past[1] = value;
         end
         default: ;
      endcase
   endtask

   // Offer one sample, with an occasional idle burst in front of it. The model
   // runs at the edge where the transaction is accepted. A typed row puts its
   // own expectation in the queue in place of the model's, but the model still
   // runs so that the histories stay in step.
   task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] x, input bit typed,
                              input filter_out_type typed_out);
      filter_out_type predicted;
      if (!sender_calm && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tdata  <= REQ_DATA_W'(x);
      req_tvalid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!(req_tvalid && req_tready));
      predicted = filter_step(x);
      pending_outputs.insert(pending_outputs.size(), typed ? typed_out : predicted);
   endtask

   // Result-side back-pressure comes in bursts of stalled cycles. The
   // stalls stop once the tail of the run is reached.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker and run limit. Inputs and outputs are read at the rising
   // edge, before that edge's updates land. Each result transaction is compared
   // field by field with the oldest prediction.
   always @(posedge clock) begin : check_outputs
      filter_out_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("output %h arrived with none expected", rsp_tdata));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_tdata[SAMPLE_WIDTH-1:0] !== want.sample) begin
               report_mismatch($sformatf("sample_out %h, expected %h",
                                         rsp_tdata[SAMPLE_WIDTH-1:0], want.sample));
            end
            if (rsp_tdata[SAMPLE_WIDTH] !== want.saturated) begin
               report_mismatch($sformatf("saturated %b, expected %b",
                                         rsp_tdata[SAMPLE_WIDTH], want.saturated));
            end
            if (rsp_tdata[RSP_DATA_W-1:SAMPLE_WIDTH+1] !== '0) begin
               report_mismatch($sformatf("padding bits %h are not zero",
                                         rsp_tdata[RSP_DATA_W-1:SAMPLE_WIDTH+1]));
            end
         end
      end
   end

   initial begin
      coef_mode_type           mode;
      logic [SAMPLE_WIDTH-1:0] x;
      logic [CSR_DATA_W-1:0]   divisor;
      int                      sent;
      int                      phase_len;
      int                      pause_at;

      // Out of reset the filter is b0 = a0 = 1.0, so it passes each sample
      // through unchanged, the range limits included.
      add_sample(SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b0);
      add_sample(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b0);
      add_sample(16'h0000, 1'b1, 16'h0000, 1'b0);
      add_sample(16'h0001, 1'b1, 16'h0001, 1'b0);
      add_sample(16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
      // With b0 just under 2.0, full-scale inputs saturate. Small inputs show
      // truncation toward zero: -1.99 comes out as -1.
      add_write(REG_B0, 16'h7FFF);
      add_sample(SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b1);
      add_sample(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b1);
      add_sample(16'h0001, 1'b1, 16'h0001, 1'b0);
      add_sample(16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
      // b0 = -2.0 times the most negative sample is the largest positive sum.
      add_write(REG_B0, 16'h8000);
      add_sample(SAMPLE_MIN, 1'b1, SAMPLE_MAX, 1'b1);
      // Zero divisor: the sign of the sum picks the limit, and a zero sum gives
      // zero without the flag.
      add_write(REG_A0, 16'h0000);
      add_sample(16'h0005, 1'b1, SAMPLE_MIN, 1'b1);
      add_sample(16'h0000, 1'b1, 16'h0000, 1'b0);
      add_sample(16'hFFFB, 1'b1, SAMPLE_MAX, 1'b1);
      // Bit 15 of the divisor write is dropped, so this sets a0 to 1.
      add_write(REG_A0, 16'h8001);
      add_sample(16'h0001, 1'b1, SAMPLE_MIN, 1'b0);
      add_sample(16'hFFFF, 1'b1, SAMPLE_MAX, 1'b1);
      // Largest divisor.
      add_write(REG_A0, 16'h7FFF);
      add_sample(SAMPLE_MAX, 1'b1, SAMPLE_MIN, 1'b0);
      // Feedback at its extremes, with the output history reloaded at the
      // negative limit. From here on the model supplies every expectation.
      add_write(REG_B1, 16'h7FFF);
      add_write(REG_B2, 16'h8000);
      add_write(REG_A1, 16'h8000);
      add_write(REG_A2, 16'h7FFF);
      add_write(REG_INIT_Y, 16'h8000);
      add_write(REG_A0, {1'b0, A0_ONE});
      add_sample(SAMPLE_MAX, 1'b0, '0, 1'b0);
      add_sample(SAMPLE_MIN, 1'b0, '0, 1'b0);
      add_sample(16'h0000, 1'b0, '0, 1'b0);
      add_sample(16'h3039, 1'b0, '0, 1'b0);
      // A write to the unused index changes nothing. Then the history is
      // reloaded at the positive limit.
      add_write(REG_UNUSED, 16'hFFFF);
      add_write(REG_INIT_Y, 16'h7FFF);
      add_sample(16'h0000, 1'b0, '0, 1'b0);
      add_sample(16'hFFFF, 1'b0, '0, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            write_register(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_sample(directed_rows[i].value, directed_rows[i].typed,
                        '{directed_rows[i].want_sample, directed_rows[i].want_sat});
         end
      end

      // Random phases. Each phase loads a fresh set of coefficients with the
      // unit idle, then streams samples. Somewhere inside each phase that runs
      // to its full length the sender holds off until all outputs are back.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = coef_mode_type'($urandom_range(0, 2));
         write_register(REG_B0, pick_coef(mode, 8192));
         write_register(REG_B1, pick_coef(mode, 8192));
         write_register(REG_B2, pick_coef(mode, 8192));
         write_register(REG_A1, pick_coef(mode, 12000));
         write_register(REG_A2, pick_coef(mode, 6000));
         case (mode)
            MODE_MILD: begin
               divisor = $urandom_range(0, 1) ? {1'b0, A0_ONE} : 16'($urandom_range(8192, 32767));
            end
            MODE_EXTREME: begin
               case ($urandom_range(0, 2))
                  0: divisor = 16'h0000;
                  1: divisor = 16'h0001;
                  default: divisor = 16'h7FFF;
               endcase
               divisor[CSR_DATA_W-1] = 1'($urandom_range(0, 1));
            end
            default: divisor = 16'($urandom);
         endcase
         write_register(REG_A0, divisor);
         if ($urandom_range(0, 1) == 0) begin
            write_register(REG_INIT_Y, pick_coef(mode, 1000));
         end
         if ($urandom_range(0, 5) == 0) begin
            write_register(REG_UNUSED, 16'($urandom));
         end
         sender_calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 90);
         pause_at = $urandom_range(1, phase_len - 1);
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            if (k == pause_at) begin
               drain_outputs();
            end
            quiet_tail = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
            case ($urandom_range(0, 7))
               0: x = SAMPLE_MAX;
               1: x = SAMPLE_MIN;
               2, 3: x = 16'($urandom_range(0, 511)) - 16'd256;
               default: x = 16'($urandom);
            endcase
            send_sample(x, 1'b0, '0);
            sent++;
         end
      end

      // Let every prediction come back, then watch a while longer for strays.
      drain_outputs();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_outputs.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/iirdf_pkg.sv
rtl/iirdf_divider.sv
rtl/iir_direct_form_filter_unit.sv
tb/sv/testbench.sv
